>>> src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Holds the transfer structs, action and status codes, the controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int NW = OPERAND_WIDTH;      // numerator width
  localparam int DW = OPERAND_WIDTH - 1;  // denominator width
  localparam int PW = 2 * OPERAND_WIDTH;  // product width
  localparam int CW = $clog2(PW + 1);     // bit counter width

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_EQ  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIVZERO  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_equal;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_GCD_START,
    S_GCD_DIV,
    S_GCD_STEP,
    S_RED_N,
    S_RED_NW,
    S_RED_D,
    S_RED_DW,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture operands
    logic mul1;      // first products
    logic mul2;      // second products
    logic comb;      // combine into num/den magnitudes
    logic gcd_init;  // x=nmag, y=dmag
    logic div_start; // start x % y or quotient division
    logic div_sel;   // 0: x/y, 1: n/g or d/g (see red_sel)
    logic red_sel;   // 0: reduce num, 1: reduce den
    logic gcd_step;  // x=y, y=rem
    logic take_nq;   // store reduced num
    logic take_dq;   // store reduced den
    logic finish;    // build result
  } dp_cmd_t;

  typedef struct packed {
    logic early;     // result known without gcd
    logic y_zero;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> src/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider: restoring divider, one quotient bit per cycle
// Unsigned PW-bit dividend and divisor, gives quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_divider
  import rau_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [PW-1:0] dividend,
  input  wire logic [PW-1:0] divisor,
  output logic               done,
  output logic [PW-1:0]      quo,
  output logic [PW-1:0]      rem
);
  logic [CW-1:0] cnt;
  logic          busy;
  logic [PW-1:0] dvs;
  logic [PW:0]   trial;

  assign trial = {rem, quo[PW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(PW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[PW]) begin
        rem <= trial[PW-1:0];
        quo <= {quo[PW-2:0], 1'b1};
      end else begin
        rem <= {rem[PW-2:0], quo[PW-1]};
        quo <= {quo[PW-2:0], 1'b0};
      end
    end
  end
endmodule

`default_nettype wire

>>> src/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, multiplier, gcd and reduction registers
// Executes the controller's commands one step at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath
  import rau_pkg::*;
(
  input  wire logic      clk,
  input  wire in_item_t  in_item,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  output out_item_t      result
);
  logic [2:0]            act;
  logic signed [NW-1:0]  an, bn;
  logic signed [NW:0]    ad, bd;
  logic signed [PW-1:0]  p1, p2;
  logic signed [PW+1:0]  num;
  logic                  neg;
  logic [PW-1:0]         nmag, dmag, x, y, nq, dq;
  logic                  early_v;
  out_item_t             early_r;
  logic [PW-1:0]         dv_a, dv_b, quo, rem;
  logic                  dv_done;
  logic signed [NW:0]    m_a, m_b;
  logic signed [2*NW+1:0] prod;
  logic                  bad_den;
  logic [PW-1:0]         lim;

  // operands as the unit reads them
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= in_item.action;
      an  <= in_item.a_num[NW-1:0];
      bn  <= in_item.b_num[NW-1:0];
      ad  <= {2'b00, in_item.a_den[DW-1:0]};
      bd  <= {2'b00, in_item.b_den[DW-1:0]};
    end
  end

  // multiplier shared by the first and second product steps
  always_comb begin
    m_a = '0;
    m_b = '0;
    if (cmd.mul1) begin
      m_a = {an[NW-1], an};
      m_b = (act == ACT_MUL) ? {bn[NW-1], bn} : bd;
    end else begin
      m_a = (act == ACT_MUL || act == ACT_DIV) ? ad : {bn[NW-1], bn};
      m_b = (act == ACT_DIV) ? {bn[NW-1], bn} : ad;
      if (act == ACT_MUL) m_b = bd;
    end
    prod = m_a * m_b;
  end

  assign bad_den = (ad == '0) || (bd == '0);

  always_ff @(posedge clk) begin
    if (cmd.mul1) p1 <= prod[PW-1:0];
    if (cmd.mul2) p2 <= prod[PW-1:0];
  end

  // numerator at full width; add/sub combine the two cross products
  always_comb begin
    num = {{2{p1[PW-1]}}, p1};
    if (act == ACT_ADD) begin
      num = {{2{p1[PW-1]}}, p1} + {{2{p2[PW-1]}}, p2};
    end else if (act == ACT_SUB) begin
      num = {{2{p1[PW-1]}}, p1} - {{2{p2[PW-1]}}, p2};
    end
  end

  // for add/sub p1 = an*bd, p2 = bn*ad; den is ad*bd, rebuilt in mul stage
  // so den register is loaded separately below
  logic signed [PW-1:0] dd;
  always_ff @(posedge clk) begin
    if (cmd.mul1) dd <= ad * bd;
  end

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      early_v          <= 1'b1;
      early_r.res_num  <= '0;
      early_r.res_den  <= 31'd1;
      early_r.is_equal <= 1'b0;
      early_r.status   <= ST_OK;
      if (bad_den) begin
        early_r.status <= ST_DIVZERO;
      end else if (act == ACT_EQ) begin
        early_r.is_equal <= (p1 == p2);
      end else if (act == ACT_DIV && bn == '0) begin
        early_r.status <= ST_DIVZERO;
      end else if (act > ACT_EQ) begin
        early_v <= 1'b1;
      end else if (((act == ACT_ADD || act == ACT_SUB) ? num : {{2{p1[PW-1]}}, p1})
                   == '0) begin
        early_v <= 1'b1;
      end else begin
        early_v <= 1'b0;
      end
      if (act == ACT_ADD || act == ACT_SUB) begin
        neg  <= num[PW+1] ^ dd[PW-1];
        nmag <= PW'(num[PW+1] ? -num : num);
        dmag <= dd[PW-1] ? PW'(-dd) : PW'(dd);
      end else begin
        neg  <= p1[PW-1] ^ p2[PW-1];
        nmag <= p1[PW-1] ? PW'(-p1) : PW'(p1);
        dmag <= p2[PW-1] ? PW'(-p2) : PW'(p2);
      end
    end
  end

  always_comb begin
    dv_a = x;
    dv_b = y;
    if (cmd.div_sel) begin
      dv_a = cmd.red_sel ? dmag : nmag;
      dv_b = x;
    end
  end

  rau_divider u_div (
    .clk      (clk),
    .rst      (1'b0),
    .start    (cmd.div_start),
    .dividend (dv_a),
    .divisor  (dv_b),
    .done     (dv_done),
    .quo      (quo),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      x <= nmag;
      y <= dmag;
    end else if (cmd.gcd_step) begin
      x <= y;
      y <= rem;
    end
    if (cmd.take_nq) nq <= quo;
    if (cmd.take_dq) dq <= quo;
  end

  assign lim = (PW'(1) << (NW - 1)) - PW'(1);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (early_v) begin
        result <= early_r;
      end else if (dq > lim || nq > (neg ? lim + PW'(1) : lim)) begin
        result.res_num  <= '0;
        result.res_den  <= 31'd1;
        result.is_equal <= 1'b0;
        result.status   <= ST_OVERFLOW;
      end else begin
        result.res_num  <= 32'(signed'(neg ? NW'(-nq) : NW'(nq)));
        result.res_den  <= 31'(dq[DW-1:0]);
        result.is_equal <= 1'b0;
        result.status   <= ST_OK;
      end
    end
  end

  assign stat.early    = early_v;
  assign stat.y_zero   = (y == '0);
  assign stat.div_done = dv_done;
endmodule

`default_nettype wire

>>> src/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer for the rational arithmetic unit
// Steps multiply, combine, gcd loop and reduction (skipped for early results), then holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);
  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    in_stall       = (state != S_IDLE);
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin cmd.mul1 = 1'b1; state_next = S_MUL2; end
      S_MUL2: begin cmd.mul2 = 1'b1; state_next = S_COMB; end
      S_COMB: begin cmd.comb = 1'b1; state_next = S_GCD_START; end
      S_GCD_START: begin
        if (stat.early) begin
          state_next = S_OUT;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = S_GCD_DIV;
        end
      end
      S_GCD_DIV: begin
        if (stat.y_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_RED_NW;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_GCD_STEP;
        end
      end
      S_GCD_STEP: if (stat.div_done) begin
        cmd.gcd_step = 1'b1;
        state_next   = S_GCD_DIV;
      end
      S_RED_NW: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) begin
          cmd.take_nq = 1'b1;
          state_next  = S_RED_D;
        end
      end
      S_RED_N: state_next = S_RED_D;
      S_RED_D: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        cmd.red_sel   = 1'b1;
        state_next    = S_RED_DW;
      end
      S_RED_DW: begin
        cmd.div_sel = 1'b1;
        cmd.red_sel = 1'b1;
        if (stat.div_done) begin
          cmd.take_dq = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: if (!(out_valid && out_stall)) begin
        cmd.finish     = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

`default_nettype wire

>>> src/rational_arith_unit.sv
// results known without reduction (zero, equality, divide-by-zero) skip the
// gcd loop; otherwise each gcd step and the two reducing divisions run on
// one 64-bit restoring divider (one bit per cycle).
// throughput: one item at a time; the next is accepted once the result has
// moved to the output register. reset: rst (synchronous) clears state and
// the output valid.
// ----------------------------------------------------------------------------
// rational_arith_unit: add, subtract, multiply, divide and compare fractions
// Cross products at double width, reduction by a iterative euclidean gcd.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rau_datapath u_dp (
    .clk     (clk),
    .in_item (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .result  (out_data)
  );
endmodule

`default_nettype wire

>>> dv/tb_rational_arith_unit.sv
// ----------------------------------------------------------------------------
// tb_rational_arith_unit: self-checking bench for the rational arithmetic unit
// Drives fraction pairs with every action, predicts the reduced result with
// exact 64-bit arithmetic and a euclidean gcd, and checks each output transfer
// in order under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rational_arith_unit;
  import rau_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t expected_q[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_off = 1'b0;
  longint    cycle_cnt = 0;

  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  rational_arith_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_item_t fraction_result(in_item_t it);
    out_item_t r;
    longint an, ad, bn, bd, num, den;
    longint unsigned nm, dm, g, lim;
    bit neg;
    r = '0;
    r.res_den = 31'd1;
    r.status = ST_OK;
    an = longint'(it.a_num);
    bn = longint'(it.b_num);
    ad = longint'({1'b0, it.a_den});
    bd = longint'({1'b0, it.b_den});
    lim = 64'h7FFF_FFFF;
    if (ad == 0 || bd == 0) begin
      r.status = ST_DIVZERO;
      return r;
    end
    case (it.action)
      ACT_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      ACT_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      ACT_MUL: begin num = an * bn; den = ad * bd; end
      ACT_DIV: begin
        if (bn == 0) begin
          r.status = ST_DIVZERO;
          return r;
        end
        num = an * bd;
        den = ad * bn;
      end
      ACT_EQ: begin
        r.is_equal = (an * bd == bn * ad);
        return r;
      end
      default: return r;
    endcase
    if (num == 0) return r;
    neg = (num < 0) != (den < 0);
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (dm > lim || nm > (neg ? lim + 1 : lim)) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.res_num = neg ? 32'(-nm) : 32'(nm);
    r.res_den = 31'(dm);
    return r;
  endfunction

  // receiver stall, driven at the falling edge
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // check each output transfer
  always @(posedge clk) begin
    out_item_t exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.res_num !== exp_r.res_num)
          $display("%0t: res_num exp %0d got %0d", $time, exp_r.res_num, out_data.res_num);
        if (out_data.res_den !== exp_r.res_den)
          $display("%0t: res_den exp %0d got %0d", $time, exp_r.res_den, out_data.res_den);
        if (out_data.is_equal !== exp_r.is_equal)
          $display("%0t: is_equal exp %0b got %0b", $time, exp_r.is_equal, out_data.is_equal);
        if (out_data.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_data.status);
        if (out_data !== exp_r) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_rational_arith_unit: FAIL");
      $finish;
    end
  end

  // valid and payload change at the falling edge only
  task automatic send_fraction_pair(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(fraction_result(it));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [30:0] rand_den();
    case ($urandom_range(3))
      0: return 31'($urandom_range(1, 16));
      1: return 31'($urandom_range(1, 1000));
      2: return 31'($urandom) | 31'd1;
      default: return 31'(32'h7FFF_FFFF >> $urandom_range(30));
    endcase
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(0, 40)) - 20);
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_pair();
    in_item_t it;
    it.action = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
    it.a_num = rand_num();
    it.b_num = rand_num();
    it.a_den = ($urandom_range(49) == 0) ? 31'd0 : rand_den();
    it.b_den = ($urandom_range(49) == 0) ? 31'd0 : rand_den();
    if (it.action == ACT_EQ && $urandom_range(1)) begin
      // scaled copy so equality can hit
      it.b_num = it.a_num;
      it.b_den = it.a_den;
      if (it.a_den < 31'd1000 && it.a_num < 1000 && it.a_num > -1000) begin
        it.b_num = it.a_num * 3;
        it.b_den = it.a_den * 3;
      end
    end
    return it;
  endfunction

  task automatic test_directed();
    action_t acts[5] = '{ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_EQ};
    in_item_t it;
    foreach (acts[i]) begin
      send_fraction_pair('{acts[i], 32'sd1, 31'd2, 32'sd1, 31'd3});
      send_fraction_pair('{acts[i], 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1});
    end
    send_fraction_pair('{ACT_DIV, 32'sd5, 31'd7, 32'sd0, 31'd3});       // zero divisor
    send_fraction_pair('{ACT_ADD, 32'sd5, 31'd0, 32'sd1, 31'd3});       // zero denominator
    send_fraction_pair('{ACT_EQ, 32'sd1, 31'd2, 32'sd1, 31'd0});
    send_fraction_pair('{ACT_SUB, 32'sd3, 31'd4, 32'sd3, 31'd4});       // zero result
    send_fraction_pair('{ACT_MUL, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1}); // overflow
    send_fraction_pair('{ACT_ADD, 32'h7FFF_FFFF, 31'd1, 32'sd1, 31'd1});
    send_fraction_pair('{ACT_DIV, 32'sd1, 31'h7FFF_FFFF, 32'sd1, 31'd2}); // largest denominator, no overflow
    send_fraction_pair('{ACT_DIV, 32'sd3, 31'd5, -32'sd7, 31'd2});      // sign to numerator
    send_fraction_pair('{ACT_EQ, 32'sd2, 31'd4, 32'sd1, 31'd2});        // unreduced equal
    send_fraction_pair('{ACT_MUL, 32'sd4, 31'd6, 32'sd9, 31'd8});
    it = '{3'd5, 32'sd1, 31'd1, 32'sd1, 31'd1};
    send_fraction_pair(it);
    it.action = 3'd7;
    send_fraction_pair(it);
    wait_drained();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_fraction_pair(rand_pair());
    wait_drained();
  endtask

  // output held off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (20) send_fraction_pair(rand_pair());
    join
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(160, 0, 0);
    test_random(160, 71, 0);
    test_random(160, 0, 71);
    test_random(120, 8, 8);
    test_backpressure();
    wait_drained();
    repeat (400) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_rational_arith_unit: PASS");
    end else begin
      $display("tb_rational_arith_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
